// ----- hw/rtl/tkvt_pkg.sv -----
`default_nettype none
package tkvt_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CFG_W       = 4;
    localparam int LABEL_W     = 17;
    localparam int INDEX_W     = 16;
    localparam int VALUE_W     = 24;
    localparam int RANK_W      = 3;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 48;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic signed [LABEL_W-1:0] LABEL_EMPTY = '1;

    typedef struct packed {
        logic load_item;
        logic scan_start;
        logic scan_step;
        logic scan_max;
        logic update;
        logic emit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic scan_last;
        logic rank_last;
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tkvt_ctrl.sv -----
`default_nettype none
module tkvt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic          s_tuser,
    input  wire tkvt_pkg::sts_t sts,
    output tkvt_pkg::cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MIN_SCAN = 3'd1;
    localparam logic [2:0] ST_UPDATE   = 3'd2;
    localparam logic [2:0] ST_MAX_SCAN = 3'd3;
    localparam logic [2:0] ST_EMIT     = 3'd4;
    localparam logic [2:0] ST_CLEAR    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_item  = 1'b1;
                    cmd.scan_start = 1'b1;
                    if (sts.n_zero)
                        state_next = (s_tuser == tkvt_pkg::OP_FLUSH) ? ST_CLEAR : ST_IDLE;
                    else
                        state_next = (s_tuser == tkvt_pkg::OP_FLUSH) ? ST_MAX_SCAN
                                                                      : ST_MIN_SCAN;
                end
            end
            ST_MIN_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MAX_SCAN:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_max  = 1'b1;
                if (sts.scan_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.rank_last)
                        state_next = ST_CLEAR;
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_MAX_SCAN;
                    end
                end
            end
            ST_CLEAR:
            begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tkvt_datapath.sv -----
`default_nettype none
module tkvt_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire tkvt_pkg::cmd_t                 cmd,
    output tkvt_pkg::sts_t                      sts,
    input  wire logic [tkvt_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic                           cfg_valid,
    input  wire logic [tkvt_pkg::CFG_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tkvt_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    logic [tkvt_pkg::CFG_W-1:0]                cfg_reg;
    logic [tkvt_pkg::CNT_W-1:0]                n_cnt;
    logic [tkvt_pkg::CNT_W-1:0]                n_last;

    logic [tkvt_pkg::INDEX_W-1:0]              item_label_reg;
    logic [tkvt_pkg::VALUE_W-1:0]              item_value_reg;

    logic signed [tkvt_pkg::LABEL_W-1:0]       slot_label_reg [tkvt_pkg::MAX_ENTRIES];
    logic [tkvt_pkg::VALUE_W-1:0]              slot_value_reg [tkvt_pkg::MAX_ENTRIES];
    logic [tkvt_pkg::MAX_ENTRIES-1:0]          done_reg;

    logic [tkvt_pkg::IDX_W-1:0]                idx_reg;
    logic                                      best_found_reg;
    logic [tkvt_pkg::IDX_W-1:0]                best_idx_reg;
    logic [tkvt_pkg::VALUE_W-1:0]              best_val_reg;
    logic signed [tkvt_pkg::LABEL_W-1:0]       best_lbl_reg;
    logic [tkvt_pkg::RANK_W-1:0]               rank_reg;

    logic [tkvt_pkg::RANK_W-1:0]               out_rank_reg;
    logic signed [tkvt_pkg::LABEL_W-1:0]       out_lbl_reg;
    logic [tkvt_pkg::VALUE_W-1:0]              out_val_reg;
    logic                                      out_last_reg;
    logic                                      out_valid_reg;

    logic [tkvt_pkg::VALUE_W-1:0]              cur_val;
    logic signed [tkvt_pkg::LABEL_W-1:0]       cur_lbl;
    logic                                      cand;

    assign n_cnt  = (32'(cfg_reg) > tkvt_pkg::MAX_ENTRIES)
                    ? tkvt_pkg::CNT_W'(tkvt_pkg::MAX_ENTRIES) : tkvt_pkg::CNT_W'(cfg_reg);
    assign n_last = n_cnt - tkvt_pkg::CNT_W'(1);

    assign cur_val = slot_value_reg[idx_reg];
    assign cur_lbl = slot_label_reg[idx_reg];

    always_comb
    begin
        if (cmd.scan_max)
            cand = !done_reg[idx_reg] && (!best_found_reg || cur_val > best_val_reg);
        else
            cand = !best_found_reg || cur_val < best_val_reg;
    end

    assign sts.n_zero    = (n_cnt == '0);
    assign sts.scan_last = (tkvt_pkg::CNT_W'(idx_reg) == n_last);
    assign sts.rank_last = (tkvt_pkg::CNT_W'(rank_reg) == n_last);
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0, out_val_reg, out_lbl_reg, out_rank_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
            cfg_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_label_reg <= s_tdata[tkvt_pkg::INDEX_W-1:0];
            item_value_reg <= s_tdata[tkvt_pkg::INDEX_W +: tkvt_pkg::VALUE_W];
        end
        if (cmd.scan_step && cand)
        begin
            best_idx_reg <= idx_reg;
            best_val_reg <= cur_val;
            best_lbl_reg <= cur_lbl;
        end
        if (cmd.emit)
        begin
            out_rank_reg <= rank_reg;
            out_lbl_reg  <= best_lbl_reg;
            out_val_reg  <= best_val_reg;
            out_last_reg <= sts.rank_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            best_found_reg <= 1'b0;
            rank_reg       <= '0;
            done_reg       <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < tkvt_pkg::MAX_ENTRIES; i++)
            begin
                slot_label_reg[i] <= tkvt_pkg::LABEL_EMPTY;
                slot_value_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.scan_start)
            begin
                idx_reg        <= '0;
                best_found_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + tkvt_pkg::IDX_W'(1);
                if (cand)
                    best_found_reg <= 1'b1;
            end

            if (cmd.update && item_value_reg > best_val_reg)
            begin
                slot_value_reg[best_idx_reg] <= item_value_reg;
                slot_label_reg[best_idx_reg] <= $signed({1'b0, item_label_reg});
            end

            if (cmd.emit)
            begin
                out_valid_reg          <= 1'b1;
                done_reg[best_idx_reg] <= 1'b1;
                rank_reg               <= rank_reg + tkvt_pkg::RANK_W'(1);
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cmd.clear)
            begin
                done_reg <= '0;
                rank_reg <= '0;
                for (int i = 0; i < tkvt_pkg::MAX_ENTRIES; i++)
                begin
                    slot_label_reg[i] <= tkvt_pkg::LABEL_EMPTY;
                    slot_value_reg[i] <= '0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/top_k_violation_tracker_core.sv -----
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    tdata: restraint_index, violation; tuser: op
// m_*      out  m_tvalid/m_tready    tdata: rank, slot_restraint, slot_violation; tlast
// cfg_*    in   cfg_valid/cfg_ready  cfg_data: entries_in_use
//
// One word at a time. An offer is accepted, then the slots in use are scanned for the
// minimum through one read port, and the word is written back if strictly larger.
// At end of frame each result is a max scan over the slots in use plus a load of the
// output register; after the last result a clear step empties all slots.
// Output stalls hold the sequencer in its emit step; cfg_ready is high only when idle.
// Reset is asynchronous, active low; slots reset to label -1, value 0, count to 0.
`default_nettype none
module top_k_violation_tracker_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tkvt_pkg::IN_DATA_W-1:0] s_tdata,   // [15:0] restraint_index, [39:16] violation
    input  wire logic                           s_tuser,   // [0] op
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tkvt_pkg::OUT_DATA_W-1:0]     m_tdata,   // [2:0] rank, [19:3] slot_restraint, [43:20] slot_violation
    output logic                                m_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tkvt_pkg::CFG_W-1:0]     cfg_data   // [3:0] entries_in_use
);

    tkvt_pkg::cmd_t cmd;
    tkvt_pkg::sts_t sts;
    logic           cfg_write;

    assign cfg_ready = s_tready && !s_tvalid;
    assign cfg_write = cfg_valid && cfg_ready;

    tkvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    tkvt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_write),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit while output word still pending");

    a_idle_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cmd.scan_step && !cmd.emit && !cmd.update)
        else $error("datapath busy while accepting input");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.rank_last) |=> cmd.clear)
        else $error("slots not cleared after last result");

    a_tlast_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !sts.n_zero |-> (m_tvalid && m_tlast))
        else $error("clear without last result pending");

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int DRAIN_CYCLES = 100;
    localparam int LIMIT_NS     = 2_000_000;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic                           op;
        logic [tkvt_pkg::INDEX_W-1:0]   idx;
        logic [tkvt_pkg::VALUE_W-1:0]   val;      // register value in [CFG_W-1:0] for ROW_CFG
        logic                           typed;
        logic [tkvt_pkg::LABEL_W-1:0]   t_label;
        logic [tkvt_pkg::VALUE_W-1:0]   t_value;
    } stim_row_t;

    typedef struct packed {
        logic [tkvt_pkg::RANK_W-1:0]  rank;
        logic [tkvt_pkg::LABEL_W-1:0] label;
        logic [tkvt_pkg::VALUE_W-1:0] value;
        logic                         last;
    } ranked_slot_t;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [tkvt_pkg::IN_DATA_W-1:0]     s_tdata;
    logic                               s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [tkvt_pkg::OUT_DATA_W-1:0]    m_tdata;
    logic                               m_tlast;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [tkvt_pkg::CFG_W-1:0]         cfg_data;

    logic [tkvt_pkg::LABEL_W-1:0]       held_label [tkvt_pkg::MAX_ENTRIES];
    logic [tkvt_pkg::VALUE_W-1:0]       held_value [tkvt_pkg::MAX_ENTRIES];
    logic [tkvt_pkg::CFG_W-1:0]         track_count;
    ranked_slot_t                       expected_slots [$];
    stim_row_t                          directed_rows [$];
    int                                 src_gap;
    int                                 sink_gap;
    int                                 errors;

    top_k_violation_tracker_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int active_slots();
        return (track_count > tkvt_pkg::MAX_ENTRIES) ? tkvt_pkg::MAX_ENTRIES
                                                     : int'(track_count);
    endfunction

    function automatic void clear_slots();
        for (int i = 0; i < tkvt_pkg::MAX_ENTRIES; i++)
        begin
            held_label[i] = tkvt_pkg::LABEL_EMPTY;
            held_value[i] = '0;
        end
    endfunction

    // replace the first smallest tracked slot if strictly beaten
    function automatic void offer_violation(input logic [tkvt_pkg::INDEX_W-1:0] idx,
                                            input logic [tkvt_pkg::VALUE_W-1:0] val);
        int n;
        int low;
        n = active_slots();
        if (n == 0)
            return;
        low = 0;
        for (int i = 1; i < n; i++)
            if (held_value[i] < held_value[low])
                low = i;
        if (val > held_value[low])
        begin
            held_value[low] = val;
            held_label[low] = {1'b0, idx};
        end
    endfunction

    // sort tracked slots descending, lower slot wins ties, then clear all
    function automatic void close_frame(input bit push);
        ranked_slot_t sorted [tkvt_pkg::MAX_ENTRIES];
        int n;
        int r;
        n = active_slots();
        for (int i = 0; i < n; i++)
        begin
            r = 0;
            for (int j = 0; j < n; j++)
                if (held_value[j] > held_value[i] ||
                    (held_value[j] == held_value[i] && j < i))
                    r++;
            sorted[r].rank  = tkvt_pkg::RANK_W'(r);
            sorted[r].label = held_label[i];
            sorted[r].value = held_value[i];
            sorted[r].last  = (r == n - 1);
        end
        if (push)
            for (int i = 0; i < n; i++)
                expected_slots.push_back(sorted[i]);
        clear_slots();
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic send_word(input logic op, input logic [tkvt_pkg::INDEX_W-1:0] idx,
                             input logic [tkvt_pkg::VALUE_W-1:0] val, input bit typed,
                             input logic [tkvt_pkg::LABEL_W-1:0] t_label,
                             input logic [tkvt_pkg::VALUE_W-1:0] t_value);
        ranked_slot_t slot;
        int n;
        while ($urandom_range(99) < src_gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == tkvt_pkg::OP_OFFER)
            offer_violation(idx, val);
        else if (typed)
        begin
            n = active_slots();
            for (int r = 0; r < n; r++)
            begin
                slot.rank  = tkvt_pkg::RANK_W'(r);
                slot.label = t_label;
                slot.value = t_value;
                slot.last  = (r == n - 1);
                expected_slots.push_back(slot);
            end
            close_frame(1'b0);
        end
        else
            close_frame(1'b1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_slots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_entries(input logic [tkvt_pkg::CFG_W-1:0] k);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        track_count = k;
    endtask

    task automatic stage(input row_kind_t kind, input logic op,
                         input logic [tkvt_pkg::INDEX_W-1:0] idx,
                         input logic [tkvt_pkg::VALUE_W-1:0] val,
                         input bit typed, input logic [tkvt_pkg::LABEL_W-1:0] t_label,
                         input logic [tkvt_pkg::VALUE_W-1:0] t_value);
        stim_row_t row;
        row.kind    = kind;
        row.op      = op;
        row.idx     = idx;
        row.val     = val;
        row.typed   = typed;
        row.t_label = t_label;
        row.t_value = t_value;
        directed_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        ranked_slot_t got;
        ranked_slot_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.rank  = m_tdata[tkvt_pkg::RANK_W-1:0];
            got.label = m_tdata[tkvt_pkg::RANK_W +: tkvt_pkg::LABEL_W];
            got.value = m_tdata[tkvt_pkg::RANK_W + tkvt_pkg::LABEL_W +: tkvt_pkg::VALUE_W];
            got.last  = m_tlast;
            if (expected_slots.size() == 0)
                report_mismatch($sformatf("unexpected word rank %0d", got.rank));
            else
            begin
                want = expected_slots.pop_front();
                if (got.rank != want.rank)
                    report_mismatch($sformatf("rank %0d, want %0d", got.rank, want.rank));
                if (got.label != want.label)
                    report_mismatch($sformatf("slot_restraint %h, want %h",
                                              got.label, want.label));
                if (got.value != want.value)
                    report_mismatch($sformatf("slot_violation %h, want %h",
                                              got.value, want.value));
                if (got.last != want.last)
                    report_mismatch($sformatf("tlast %b, want %b", got.last, want.last));
            end
        end
        m_tready <= ($urandom_range(99) >= sink_gap);
    end

    initial
    begin
        int k_plan [12];
        int budget;
        int sent;
        int nofs;
        int kk;
        logic [tkvt_pkg::INDEX_W-1:0] idx;
        logic [tkvt_pkg::VALUE_W-1:0] val;

        k_plan      = '{8, 15, 0, 1, 2, 5, 8, 3, 9, 4, 7, 6};
        errors      = 0;
        src_gap     = 34;
        sink_gap    = 56;
        track_count = '0;
        clear_slots();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= tkvt_pkg::OP_OFFER;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tracking off after reset: flush emits nothing, offer ignored
        stage(ROW_WORD, tkvt_pkg::OP_FLUSH, '0, '0, 1'b1, tkvt_pkg::LABEL_EMPTY, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0005, 24'd100, 1'b0, '0, '0);
        stage(ROW_CFG,  tkvt_pkg::OP_OFFER, '0, 24'd8, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_FLUSH, '0, '0, 1'b1, tkvt_pkg::LABEL_EMPTY, '0);
        // zero does not beat an empty slot
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0009, 24'd0, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_FLUSH, '0, '0, 1'b1, tkvt_pkg::LABEL_EMPTY, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'hFFFF, 24'hFFFFFF, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0000, 24'h000001, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h1234, 24'h800000, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0007, 24'h800000, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0008, 24'h800000, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h5555, 24'hAAAAAA, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'hAAAA, 24'h555555, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0100, 24'h000002, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0101, 24'h000003, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0102, 24'h800000, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_FLUSH, '0, '0, 1'b0, '0, '0);
        // single slot, equal value keeps the holder
        stage(ROW_CFG,  tkvt_pkg::OP_OFFER, '0, 24'd1, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'hFFFF, 24'hFFFFFF, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0001, 24'hFFFFFF, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_FLUSH, '0, '0, 1'b1, 17'h0FFFF, 24'hFFFFFF);
        // count shrunk mid-frame, then flush must clear the hidden slot too
        stage(ROW_CFG,  tkvt_pkg::OP_OFFER, '0, 24'd8, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0003, 24'h000010, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0004, 24'h000020, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0005, 24'h000030, 1'b0, '0, '0);
        stage(ROW_CFG,  tkvt_pkg::OP_OFFER, '0, 24'd2, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_OFFER, 16'h0006, 24'h000040, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_FLUSH, '0, '0, 1'b0, '0, '0);
        // above MAX_ENTRIES saturates
        stage(ROW_CFG,  tkvt_pkg::OP_OFFER, '0, 24'd15, 1'b0, '0, '0);
        stage(ROW_WORD, tkvt_pkg::OP_FLUSH, '0, '0, 1'b1, tkvt_pkg::LABEL_EMPTY, '0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_entries(directed_rows[i].val[tkvt_pkg::CFG_W-1:0]);
            else
                send_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                          directed_rows[i].typed, directed_rows[i].t_label,
                          directed_rows[i].t_value);
        end

        for (int m = 0; m < 3; m++)
        begin
            src_gap  = (m == 0) ? 34 : (m == 1) ? 56 : 0;
            sink_gap = (m == 0) ? 56 : (m == 1) ? 34 : 0;
            for (int p = 0; p < 4; p++)
            begin
                write_entries(tkvt_pkg::CFG_W'(k_plan[m*4+p]));
                kk     = active_slots();
                budget = (kk == 0) ? 12 : 37;
                sent   = 0;
                while (sent < budget)
                begin
                    nofs = $urandom_range(2 * kk + 2);
                    for (int o = 0; o < nofs && sent < budget; o++)
                    begin
                        case ($urandom_range(9)) inside
                            0:       val = '1;
                            1:       val = '0;
                            [2:4]:   val = tkvt_pkg::VALUE_W'($urandom_range(7));
                            default: val = tkvt_pkg::VALUE_W'($urandom());
                        endcase
                        idx = ($urandom_range(9) == 0) ? '1 : tkvt_pkg::INDEX_W'($urandom());
                        send_word(tkvt_pkg::OP_OFFER, idx, val, 1'b0, '0, '0);
                        sent++;
                    end
                    if (sent < budget)
                    begin
                        send_word(tkvt_pkg::OP_FLUSH, tkvt_pkg::INDEX_W'($urandom()),
                                  tkvt_pkg::VALUE_W'($urandom()), 1'b0, '0, '0);
                        sent++;
                    end
                end
            end
        end

        wait_idle();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/tkvt_pkg.sv
hw/rtl/tkvt_ctrl.sv
hw/rtl/tkvt_datapath.sv
hw/rtl/top_k_violation_tracker_core.sv
dv/tb_top.sv
